/* sv/assert_macros.svh */
// Assertion macros for the RTL of the mecanum wheel kinematics unit.
// Depends on nothing; define NO_ASSERTIONS to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/mwk_pkg.sv */
// Shared constants and types of the mecanum wheel kinematics unit.
// Used by every module of the block; depends on nothing.
package mwk_pkg;

  localparam int VELOCITY_BITS  = 16;
  localparam int FRACTION_BITS  = 12;
  localparam int CFG_FRAC       = 12;
  localparam int CFG_W          = 16;
  localparam int SUM_W          = VELOCITY_BITS + CFG_W + 2;
  localparam int MAG_W          = SUM_W - 1;
  localparam int SCALE_W        = 17;
  localparam int QUOT_W         = 18;
  localparam int DIV_STAGES     = 6;
  localparam int BITS_PER_STAGE = QUOT_W / DIV_STAGES;
  localparam int PROD_W         = MAG_W + SCALE_W + 1;
  localparam int OUT_W          = 17;
  localparam int CMP_W          = VELOCITY_BITS + CFG_W + CFG_FRAC + FRACTION_BITS;
  localparam int IDX_W          = 2;

  localparam logic [OUT_W-1:0]   FULL_Q15    = OUT_W'(32768);
  localparam logic [MAG_W-1:0]   MAG_FLOOR   = MAG_W'(1) << (FRACTION_BITS + CFG_FRAC);
  localparam logic [SCALE_W-1:0] LIFT_SCALE  = SCALE_W'(1) << (15 + CFG_FRAC - FRACTION_BITS);

  localparam logic [IDX_W-1:0] REG_WHEELBASE   = 2'd0;
  localparam logic [IDX_W-1:0] REG_WHEEL_SCALE = 2'd1;
  localparam logic [IDX_W-1:0] REG_LIFT_MAX    = 2'd2;

  localparam logic [CFG_W-1:0] WHEELBASE_RESET   = 16'd4096;
  localparam logic [CFG_W-1:0] WHEEL_SCALE_RESET = 16'd32768;
  localparam logic [CFG_W-1:0] LIFT_MAX_RESET    = 16'd4096;

  typedef struct packed {
    logic valid;
    logic neg;
    logic sat;
  } lane_ctl_t;

endpackage

/* sv/mecanum_wheel_kinematics_unit.sv */
// Top level of the mecanum wheel kinematics unit: command capture, registers, lanes.
// Depends on mwk_pkg, mwk_mix, mwk_lane and assert_macros.svh.

// A velocity command is taken at every clock edge with start high; busy is
// always low, so one command per cycle is sustained. Each command yields one
// result, flagged by done_o for one cycle, after it has passed through one
// capture stage, three mixing stages (sums, magnitudes, largest magnitude), one
// multiply stage, six divider stages of three quotient bits each, and one
// rounding stage. The receiver cannot stall the results. Registers must only be
// written while no command is in flight.
`include "assert_macros.svh"

module mecanum_wheel_kinematics_unit (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start,
  output logic                                      busy,
  input  logic signed [mwk_pkg::VELOCITY_BITS-1:0]  forward_velocity_i,
  input  logic signed [mwk_pkg::VELOCITY_BITS-1:0]  lateral_velocity_i,
  input  logic signed [mwk_pkg::VELOCITY_BITS-1:0]  yaw_rate_i,
  input  logic signed [mwk_pkg::VELOCITY_BITS-1:0]  lift_velocity_i,
  input  logic                                      cfg_we_i,
  input  logic [mwk_pkg::IDX_W-1:0]                 cfg_index_i,
  input  logic [mwk_pkg::CFG_W-1:0]                 cfg_data_i,
  output logic                                      done_o,
  output logic signed [mwk_pkg::OUT_W-1:0]          front_left_drive_o,
  output logic signed [mwk_pkg::OUT_W-1:0]          front_right_drive_o,
  output logic signed [mwk_pkg::OUT_W-1:0]          rear_left_drive_o,
  output logic signed [mwk_pkg::OUT_W-1:0]          rear_right_drive_o,
  output logic signed [mwk_pkg::OUT_W-1:0]          lift_drive_o
);

  localparam int VW = mwk_pkg::VELOCITY_BITS;
  localparam int MW = mwk_pkg::MAG_W;

  logic [mwk_pkg::CFG_W-1:0] wheelbase_q, wheel_scale_q, lift_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheelbase_q   <= mwk_pkg::WHEELBASE_RESET;
      wheel_scale_q <= mwk_pkg::WHEEL_SCALE_RESET;
      lift_max_q    <= mwk_pkg::LIFT_MAX_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mwk_pkg::REG_WHEELBASE:   wheelbase_q   <= cfg_data_i;
        mwk_pkg::REG_WHEEL_SCALE: wheel_scale_q <= cfg_data_i;
        mwk_pkg::REG_LIFT_MAX:    lift_max_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic                 in_valid_q;
  logic signed [VW-1:0] vx_q, vy_q, wz_q, vz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    vx_q <= forward_velocity_i;
    vy_q <= lateral_velocity_i;
    wz_q <= yaw_rate_i;
    vz_q <= lift_velocity_i;
  end

  mwk_pkg::lane_ctl_t [3:0] wheel_ctl;
  logic [3:0][MW-1:0]       wheel_mag;
  logic [MW-1:0]            wheel_div;
  mwk_pkg::lane_ctl_t       lift_ctl;
  logic [MW-1:0]            lift_mag, lift_div;

  mwk_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_q),
    .vx_i        (vx_q),
    .vy_i        (vy_q),
    .wz_i        (wz_q),
    .vz_i        (vz_q),
    .wheelbase_i (wheelbase_q),
    .lift_max_i  (lift_max_q),
    .wheel_ctl_o (wheel_ctl),
    .wheel_mag_o (wheel_mag),
    .wheel_div_o (wheel_div),
    .lift_ctl_o  (lift_ctl),
    .lift_mag_o  (lift_mag),
    .lift_div_o  (lift_div)
  );

  logic [4:0]                              lane_valid;
  logic signed [4:0][mwk_pkg::OUT_W-1:0]   lane_drive;

  for (genvar g = 0; g < 4; g++) begin : g_wheel
    mwk_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (wheel_ctl[g]),
      .mag_i   (wheel_mag[g]),
      .scale_i ({1'b0, wheel_scale_q}),
      .div_i   (wheel_div),
      .valid_o (lane_valid[g]),
      .drive_o (lane_drive[g])
    );
  end

  mwk_lane u_lift (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (lift_ctl),
    .mag_i   (lift_mag),
    .scale_i (mwk_pkg::LIFT_SCALE),
    .div_i   (lift_div),
    .valid_o (lane_valid[4]),
    .drive_o (lane_drive[4])
  );

  assign done_o              = lane_valid[0];
  assign front_left_drive_o  = lane_drive[0];
  assign front_right_drive_o = lane_drive[1];
  assign rear_left_drive_o   = lane_drive[2];
  assign rear_right_drive_o  = lane_drive[3];
  assign lift_drive_o        = lane_drive[4];

  // All five lanes carry the same transaction in lock step.
  `ASSERT_NOW(a_lanes_aligned, clk_i, rst_ni, 1'b1, (lane_valid == 5'b00000) || (lane_valid == 5'b11111))
  `ASSERT_NEXT(a_capture, clk_i, rst_ni, start && !busy, in_valid_q)
  `ASSERT_NOW(a_lift_clamped, clk_i, rst_ni, done_o, (lift_drive_o <= 17'sd32768) && (lift_drive_o >= -17'sd32768))
  `ASSERT_NOW(a_fl_clamped, clk_i, rst_ni, done_o, (front_left_drive_o <= 17'sd32768) && (front_left_drive_o >= -17'sd32768))

endmodule

/* sv/mwk_mix.sv */
// Wheel mixing front end: wheel sums, magnitudes, largest magnitude, lift prep.
// Three register stages; depends on mwk_pkg.
module mwk_mix (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  input  logic signed [mwk_pkg::VELOCITY_BITS-1:0]  vx_i,
  input  logic signed [mwk_pkg::VELOCITY_BITS-1:0]  vy_i,
  input  logic signed [mwk_pkg::VELOCITY_BITS-1:0]  wz_i,
  input  logic signed [mwk_pkg::VELOCITY_BITS-1:0]  vz_i,
  input  logic [mwk_pkg::CFG_W-1:0]                 wheelbase_i,
  input  logic [mwk_pkg::CFG_W-1:0]                 lift_max_i,
  output mwk_pkg::lane_ctl_t [3:0]                  wheel_ctl_o,
  output logic [3:0][mwk_pkg::MAG_W-1:0]            wheel_mag_o,
  output logic [mwk_pkg::MAG_W-1:0]                 wheel_div_o,
  output mwk_pkg::lane_ctl_t                        lift_ctl_o,
  output logic [mwk_pkg::MAG_W-1:0]                 lift_mag_o,
  output logic [mwk_pkg::MAG_W-1:0]                 lift_div_o
);

  localparam int SW = mwk_pkg::SUM_W;
  localparam int MW = mwk_pkg::MAG_W;
  localparam int VW = mwk_pkg::VELOCITY_BITS;

  // Stage 1: wheel sums.
  logic signed [VW+mwk_pkg::CFG_W:0] t_full;
  logic signed [SW-1:0]              x_ext, y_ext, t_ext;
  logic                              v1_q;
  logic signed [3:0][SW-1:0]         w1_q;
  logic signed [VW-1:0]              vz1_q;

  assign t_full = wz_i * $signed({1'b0, wheelbase_i});
  assign x_ext  = SW'(vx_i) <<< mwk_pkg::CFG_FRAC;
  assign y_ext  = SW'(vy_i) <<< mwk_pkg::CFG_FRAC;
  assign t_ext  = SW'(t_full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    w1_q[0] <= x_ext - y_ext - t_ext;
    w1_q[1] <= x_ext + y_ext + t_ext;
    w1_q[2] <= x_ext + y_ext - t_ext;
    w1_q[3] <= x_ext - y_ext + t_ext;
    vz1_q   <= vz_i;
  end

  // Stage 2: magnitudes and the lift saturation decision.
  logic [3:0][MW-1:0]        mag_d;
  logic [VW-1:0]             lift_abs;
  logic [mwk_pkg::CMP_W-1:0] lift_num, lift_den;
  logic                      lift_sat_d;
  logic                      v2_q;
  logic [3:0][MW-1:0]        mag2_q;
  logic [3:0]                neg2_q;
  logic [MW-1:0]             lmag2_q, ldiv2_q;
  logic                      lneg2_q, lsat2_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag_d[i] = w1_q[i][SW-1] ? MW'(-w1_q[i]) : MW'(w1_q[i]);
    end
  end

  assign lift_abs   = vz1_q[VW-1] ? VW'(-vz1_q) : VW'(vz1_q);
  assign lift_num   = mwk_pkg::CMP_W'(lift_abs) << mwk_pkg::CFG_FRAC;
  assign lift_den   = mwk_pkg::CMP_W'(lift_max_i) << mwk_pkg::FRACTION_BITS;
  // A zero command gives zero even when the maximum lift speed is zero.
  assign lift_sat_d = (lift_abs != '0) && ((lift_max_i == '0) || (lift_num >= lift_den));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mag2_q  <= mag_d;
    for (int i = 0; i < 4; i++) begin
      neg2_q[i] <= w1_q[i][SW-1];
    end
    lmag2_q <= MW'(lift_abs);
    lneg2_q <= vz1_q[VW-1];
    lsat2_q <= lift_sat_d;
    ldiv2_q <= MW'(lift_max_i);
  end

  // Stage 3: largest magnitude, floored at one.
  logic [MW-1:0] max01, max23, max_all;
  logic          v3_q;
  logic [3:0]    neg3_q;
  logic [MW-1:0] max3_q, lmag3_q, ldiv3_q;
  logic [3:0][MW-1:0] mag3_q;
  logic          lneg3_q, lsat3_q;

  assign max01   = (mag2_q[0] > mag2_q[1]) ? mag2_q[0] : mag2_q[1];
  assign max23   = (mag2_q[2] > mag2_q[3]) ? mag2_q[2] : mag2_q[3];
  assign max_all = (max01 > max23) ? max01 : max23;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mag3_q  <= mag2_q;
    neg3_q  <= neg2_q;
    max3_q  <= (max_all > mwk_pkg::MAG_FLOOR) ? max_all : mwk_pkg::MAG_FLOOR;
    lmag3_q <= lmag2_q;
    lneg3_q <= lneg2_q;
    lsat3_q <= lsat2_q;
    ldiv3_q <= ldiv2_q;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      wheel_ctl_o[i] = '{valid: v3_q, neg: neg3_q[i], sat: 1'b0};
    end
  end

  assign wheel_mag_o = mag3_q;
  assign wheel_div_o = max3_q;
  assign lift_ctl_o  = '{valid: v3_q, neg: lneg3_q, sat: lsat3_q};
  assign lift_mag_o  = lmag3_q;
  assign lift_div_o  = ldiv3_q;

endmodule

/* sv/mwk_div_step.sv */
// One registered stage of the restoring divider: three quotient bits per stage.
// Depends on mwk_pkg.
module mwk_div_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mwk_pkg::lane_ctl_t            ctl_i,
  input  logic [mwk_pkg::MAG_W-1:0]     rem_i,
  input  logic [mwk_pkg::QUOT_W-1:0]    low_i,
  input  logic [mwk_pkg::QUOT_W-1:0]    quot_i,
  input  logic [mwk_pkg::MAG_W-1:0]     div_i,
  output mwk_pkg::lane_ctl_t            ctl_o,
  output logic [mwk_pkg::MAG_W-1:0]     rem_o,
  output logic [mwk_pkg::QUOT_W-1:0]    low_o,
  output logic [mwk_pkg::QUOT_W-1:0]    quot_o,
  output logic [mwk_pkg::MAG_W-1:0]     div_o
);

  localparam int MW = mwk_pkg::MAG_W;
  localparam int QW = mwk_pkg::QUOT_W;

  logic [MW-1:0] rem_d;
  logic [QW-1:0] low_d, quot_d;
  logic [MW:0]   trial;
  logic          valid_q;
  logic          neg_q, sat_q;
  logic [MW-1:0] rem_q, div_q;
  logic [QW-1:0] low_q, quot_q;

  always_comb begin
    rem_d  = rem_i;
    low_d  = low_i;
    quot_d = quot_i;
    trial  = '0;
    for (int k = 0; k < mwk_pkg::BITS_PER_STAGE; k++) begin
      trial = {rem_d, low_d[QW-1]};
      low_d = low_d << 1;
      if (trial >= {1'b0, div_i}) begin
        trial  = trial - {1'b0, div_i};
        quot_d = {quot_d[QW-2:0], 1'b1};
      end else begin
        quot_d = {quot_d[QW-2:0], 1'b0};
      end
      rem_d = trial[MW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= ctl_i.neg;
    sat_q  <= ctl_i.sat;
    rem_q  <= rem_d;
    low_q  <= low_d;
    quot_q <= quot_d;
    div_q  <= div_i;
  end

  assign ctl_o  = '{valid: valid_q, neg: neg_q, sat: sat_q};
  assign rem_o  = rem_q;
  assign low_o  = low_q;
  assign quot_o = quot_q;
  assign div_o  = div_q;

endmodule

/* sv/mwk_lane.sv */
// One output lane: scale multiply, pipelined divide, rounding, clamp and sign.
// Depends on mwk_pkg and mwk_div_step.
module mwk_lane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mwk_pkg::lane_ctl_t                ctl_i,
  input  logic [mwk_pkg::MAG_W-1:0]         mag_i,
  input  logic [mwk_pkg::SCALE_W-1:0]       scale_i,
  input  logic [mwk_pkg::MAG_W-1:0]         div_i,
  output logic                              valid_o,
  output logic signed [mwk_pkg::OUT_W-1:0]  drive_o
);

  localparam int MW = mwk_pkg::MAG_W;
  localparam int QW = mwk_pkg::QUOT_W;
  localparam int NS = mwk_pkg::DIV_STAGES;
  localparam int OW = mwk_pkg::OUT_W;

  // Product stage: numerator magnitude times twice the scale.
  logic                        pv_q, pneg_q, psat_q;
  logic [mwk_pkg::PROD_W-1:0]  prod_q;
  logic [MW-1:0]               pdiv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pneg_q <= ctl_i.neg;
    psat_q <= ctl_i.sat;
    prod_q <= mag_i * {scale_i, 1'b0};
    // A zero divisor only occurs on saturated or zero-command lift items; one stands in for it.
    pdiv_q <= (div_i == '0) ? MW'(1) : div_i;
  end

  mwk_pkg::lane_ctl_t   ctl_s  [NS+1];
  logic [MW-1:0]        rem_s  [NS+1];
  logic [QW-1:0]        low_s  [NS+1];
  logic [QW-1:0]        quot_s [NS+1];
  logic [MW-1:0]        div_s  [NS+1];

  assign ctl_s[0]  = '{valid: pv_q, neg: pneg_q, sat: psat_q};
  assign rem_s[0]  = prod_q[mwk_pkg::PROD_W-1:QW];
  assign low_s[0]  = prod_q[QW-1:0];
  assign quot_s[0] = '0;
  assign div_s[0]  = pdiv_q;

  for (genvar g = 0; g < NS; g++) begin : g_div
    mwk_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_s[g]),
      .rem_i  (rem_s[g]),
      .low_i  (low_s[g]),
      .quot_i (quot_s[g]),
      .div_i  (div_s[g]),
      .ctl_o  (ctl_s[g+1]),
      .rem_o  (rem_s[g+1]),
      .low_o  (low_s[g+1]),
      .quot_o (quot_s[g+1]),
      .div_o  (div_s[g+1])
    );
  end

  // Round half away from zero on the magnitude, then clamp to one.
  logic [QW:0]   rounded;
  logic [OW-1:0] mag_d;
  logic          valid_q;
  logic [OW-1:0] drive_q;

  assign rounded = ({1'b0, quot_s[NS]} + (QW+1)'(1)) >> 1;
  assign mag_d   = (ctl_s[NS].sat || (rounded > (QW+1)'(mwk_pkg::FULL_Q15)))
                   ? mwk_pkg::FULL_Q15 : OW'(rounded);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_s[NS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    drive_q <= ctl_s[NS].neg ? (OW'(0) - mag_d) : mag_d;
  end

  assign valid_o = valid_q;
  assign drive_o = $signed(drive_q);

endmodule
